FILE: rtl/core/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared codes and controller/datapath interface types of the first-fit
// free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_INIT  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_NOADDR = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [1:0] REG_MEM_SIZE = 2'd0;
  localparam logic [1:0] REG_HDR_SIZE = 2'd1;

  localparam logic [16:0] MEM_SIZE_RST = 17'd65536;

  typedef struct packed {
    logic       load;
    logic       init;
    logic       fscan;
    logic       tscan;
    logic       fail;
    logic [1:0] fail_code;
    logic       commit;
    logic       shdn;
    logic       trd;
    logic       shup_start;
    logic       shup;
    logic       ins;
    logic       publish;
  } ffa_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       fhit;
    logic       fmiss;
    logic       tdone;
    logic       slot_ok;
    logic       exact;
    logic       list_full;
    logic       shdn_done;
    logic       shup_done;
    logic       out_busy;
  } ffa_stat_t;

endpackage

FILE: rtl/core/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer of the allocator: free-list walk, table walk, decision, list
// shift and result hand-off.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_action_i,
  output logic             in_ready_o,
  input  ffa_pkg::ffa_stat_t stat_i,
  output ffa_pkg::ffa_cmd_t  cmd_o
);
  import ffa_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_INITOP = 4'd2;
  localparam logic [3:0] S_FSCAN  = 4'd3;
  localparam logic [3:0] S_TSCAN  = 4'd4;
  localparam logic [3:0] S_TDEC   = 4'd5;
  localparam logic [3:0] S_TRD    = 4'd6;
  localparam logic [3:0] S_SHUPS  = 4'd7;
  localparam logic [3:0] S_SHUP   = 4'd8;
  localparam logic [3:0] S_INS    = 4'd9;
  localparam logic [3:0] S_SHDN   = 4'd10;
  localparam logic [3:0] S_PUB    = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (in_action_i)
            ACT_ALLOC: state_d = S_FSCAN;
            ACT_FREE:  state_d = S_TSCAN;
            ACT_INIT:  state_d = S_INITOP;
            default:   state_d = S_PUB;
          endcase
        end
      end
      S_INITOP: begin
        cmd_o.init = 1'b1;
        state_d    = S_PUB;
      end
      S_FSCAN: begin
        cmd_o.fscan = 1'b1;
        if (stat_i.fhit) begin
          state_d = S_TSCAN;
        end else if (stat_i.fmiss) begin
          state_d = S_PUB;
        end
      end
      S_TSCAN: begin
        cmd_o.tscan = 1'b1;
        if (stat_i.tdone) begin
          state_d = S_TDEC;
        end
      end
      S_TDEC: begin
        if (stat_i.op == ACT_ALLOC) begin
          if (!stat_i.slot_ok) begin
            cmd_o.fail      = 1'b1;
            cmd_o.fail_code = ST_FULL;
            state_d         = S_PUB;
          end else begin
            cmd_o.commit = 1'b1;
            state_d      = stat_i.exact ? S_SHDN : S_PUB;
          end
        end else if (!stat_i.slot_ok) begin
          cmd_o.fail      = 1'b1;
          cmd_o.fail_code = ST_NOADDR;
          state_d         = S_PUB;
        end else if (stat_i.list_full) begin
          cmd_o.fail      = 1'b1;
          cmd_o.fail_code = ST_FULL;
          state_d         = S_PUB;
        end else begin
          state_d = S_TRD;
        end
      end
      S_TRD: begin
        cmd_o.trd = 1'b1;
        state_d   = S_SHUPS;
      end
      S_SHUPS: begin
        cmd_o.shup_start = 1'b1;
        state_d          = S_SHUP;
      end
      S_SHUP: begin
        cmd_o.shup = 1'b1;
        if (stat_i.shup_done) begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        cmd_o.ins = 1'b1;
        state_d   = S_PUB;
      end
      S_SHDN: begin
        cmd_o.shdn = 1'b1;
        if (stat_i.shdn_done) begin
          state_d = S_PUB;
        end
      end
      S_PUB: begin
        if (!stat_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

endmodule

FILE: rtl/core/ffa_dp.sv
// ----------------------------------------------------------------------------
// ffa_dp
// Datapath of the allocator: config registers, free-list memory, allocation
// table, walk pointers and the output register.
// ----------------------------------------------------------------------------
module ffa_dp #(
  parameter int FREE_LIST_DEPTH   = 64,
  parameter int ALLOC_TABLE_DEPTH = 64,
  parameter int ADDR_BITS         = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ffa_pkg::ffa_cmd_t     cmd_i,
  output ffa_pkg::ffa_stat_t    stat_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [16:0]           cfg_wdata_i,
  input  logic [1:0]            in_action_i,
  input  logic [15:0]           in_request_i,
  input  logic [ADDR_BITS-1:0]  in_faddr_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [1:0]            out_status_o,
  output logic [ADDR_BITS-1:0]  out_addr_o,
  output logic [16:0]           out_bsize_o,
  output logic [6:0]            out_scount_o,
  output logic [6:0]            out_entries_o
);
  import ffa_pkg::*;

  localparam int A   = ADDR_BITS;
  localparam int LW  = ADDR_BITS + 1;
  localparam int FIW = $clog2(FREE_LIST_DEPTH);
  localparam int FCW = $clog2(FREE_LIST_DEPTH + 1);
  localparam int TIW = $clog2(ALLOC_TABLE_DEPTH);
  localparam int TCW = $clog2(ALLOC_TABLE_DEPTH + 1);
  localparam logic [32:0] LIM = 33'd1 << ADDR_BITS;

  typedef struct packed {
    logic [A-1:0]  start;
    logic [LW-1:0] len;
  } fent_t;

  typedef struct packed {
    logic [A-1:0]   pay;
    logic [LW-1:0]  size;
    logic [FCW-1:0] pos;
  } tent_t;

  // configuration
  logic [16:0] msize_q;
  logic [7:0]  hdr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msize_q <= MEM_SIZE_RST;
      hdr_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MEM_SIZE: msize_q <= cfg_wdata_i;
        REG_HDR_SIZE: hdr_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // request and working registers
  logic [1:0]     op_q;
  logic [16:0]    total_q;
  logic [A-1:0]   faddr_q;
  logic [FCW-1:0] count_q;
  logic [FCW-1:0] fptr_q;
  logic           fpend_q;
  logic [FIW-1:0] fpend_idx_q;
  logic [FIW-1:0] found_q;
  logic [A-1:0]   blk_start_q;
  logic [LW-1:0]  blk_len_q;
  logic [A-1:0]   addr_q;
  logic [TCW-1:0] tptr_q;
  logic           tpend_q;
  logic [TIW-1:0] tpend_idx_q;
  logic           match_ok_q, fs_ok_q;
  logic [TIW-1:0] match_q, fs_q;
  logic [ALLOC_TABLE_DEPTH-1:0] valid_q;
  logic [FCW-1:0] pos_q;
  logic [LW-1:0]  size_q;
  logic [1:0]     res_status_q;
  logic [A-1:0]   res_addr_q;
  logic [16:0]    res_bsize_q;
  logic [FCW-1:0] scount_q;

  // memories
  fent_t fmem [FREE_LIST_DEPTH];
  tent_t tmem [ALLOC_TABLE_DEPTH];
  fent_t f_rdata_q, f_wdata;
  tent_t t_rdata_q;
  logic           f_we, f_re, t_re;
  logic [FIW-1:0] f_waddr, f_raddr;
  logic [TIW-1:0] t_raddr, slot_sel;

  logic        fhit, fmiss, f_issue, tm, tdone, t_issue;
  logic [A-1:0] key;
  logic [32:0] msize_ext;
  logic [LW-1:0] init_len;
  logic [FCW-1:0] pm1;

  assign msize_ext = 33'(msize_q);
  assign init_len  = LW'((msize_ext > LIM) ? LIM : msize_ext);
  assign key       = (op_q == ACT_ALLOC) ? addr_q : faddr_q;
  assign slot_sel  = match_ok_q ? match_q : fs_q;

  assign fhit    = fpend_q && (33'(f_rdata_q.len) >= 33'(total_q));
  assign fmiss   = !fhit && (fptr_q >= count_q);
  assign f_issue = !fhit && !fmiss;

  assign tm      = tpend_q && valid_q[tpend_idx_q] && (t_rdata_q.pay == key);
  assign tdone   = tm || ((tptr_q == TCW'(ALLOC_TABLE_DEPTH)) && !tpend_q);
  assign t_issue = !tdone && (tptr_q < TCW'(ALLOC_TABLE_DEPTH));

  assign pm1 = (t_rdata_q.pos != '0) ? t_rdata_q.pos - 1'b1 : '0;

  always_comb begin
    stat_o.op        = op_q;
    stat_o.fhit      = fhit;
    stat_o.fmiss     = fmiss;
    stat_o.tdone     = tdone;
    stat_o.slot_ok   = match_ok_q || ((op_q == ACT_ALLOC) && fs_ok_q);
    stat_o.exact     = 33'(blk_len_q) == 33'(total_q);
    stat_o.list_full = count_q >= FCW'(FREE_LIST_DEPTH);
    stat_o.shdn_done = (fptr_q >= count_q) && !fpend_q;
    stat_o.shup_done = (fptr_q <= pos_q) && !fpend_q;
    stat_o.out_busy  = out_valid_o;
  end

  // free-list port control
  always_comb begin
    f_re    = 1'b0;
    f_raddr = fptr_q[FIW-1:0];
    if (cmd_i.fscan) begin
      f_re = f_issue;
    end else if (cmd_i.shdn) begin
      f_re = fptr_q < count_q;
    end else if (cmd_i.shup) begin
      f_re    = fptr_q > pos_q;
      f_raddr = FIW'(fptr_q - 1'b1);
    end
  end

  always_comb begin
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = f_rdata_q;
    if (cmd_i.init) begin
      f_we    = 1'b1;
      f_wdata = '{start: '0, len: init_len};
    end else if (cmd_i.commit && !stat_o.exact) begin
      f_we    = 1'b1;
      f_waddr = found_q;
      f_wdata = '{start: blk_start_q + A'(total_q), len: blk_len_q - LW'(total_q)};
    end else if (cmd_i.shdn && fpend_q) begin
      f_we    = 1'b1;
      f_waddr = fpend_idx_q - 1'b1;
    end else if (cmd_i.shup && fpend_q) begin
      f_we    = 1'b1;
      f_waddr = fpend_idx_q;
    end else if (cmd_i.ins) begin
      f_we    = 1'b1;
      f_waddr = pos_q[FIW-1:0];
      f_wdata = '{start: faddr_q - A'(hdr_q), len: size_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fmem[f_waddr] <= f_wdata;
    end
    if (f_re) begin
      f_rdata_q <= fmem[f_raddr];
    end
  end

  assign t_re    = (cmd_i.tscan && t_issue) || cmd_i.trd;
  assign t_raddr = cmd_i.trd ? slot_sel : tptr_q[TIW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      tmem[slot_sel] <= '{pay: addr_q, size: LW'(total_q), pos: scount_q};
    end
    if (t_re) begin
      t_rdata_q <= tmem[t_raddr];
    end
  end

  // control state of the walks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= FCW'(1);
      fptr_q     <= '0;
      fpend_q    <= 1'b0;
      tptr_q     <= '0;
      tpend_q    <= 1'b0;
      match_ok_q <= 1'b0;
      fs_ok_q    <= 1'b0;
      valid_q    <= '0;
    end else begin
      if (cmd_i.init) begin
        count_q <= FCW'(1);
        valid_q <= '0;
      end
      if (cmd_i.load) begin
        fptr_q     <= '0;
        fpend_q    <= 1'b0;
        tptr_q     <= '0;
        tpend_q    <= 1'b0;
        match_ok_q <= 1'b0;
        fs_ok_q    <= 1'b0;
      end
      if (cmd_i.fscan || cmd_i.shdn) begin
        fpend_q <= f_re;
        if (f_re) begin
          fptr_q <= fptr_q + 1'b1;
        end
      end
      if (cmd_i.shup) begin
        fpend_q <= f_re;
        if (f_re) begin
          fptr_q <= fptr_q - 1'b1;
        end
      end
      if (cmd_i.shdn && stat_o.shdn_done) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.commit) begin
        fptr_q           <= FCW'(found_q) + 1'b1;
        fpend_q          <= 1'b0;
        valid_q[slot_sel] <= 1'b1;
      end
      if (cmd_i.shup_start) begin
        fptr_q  <= count_q;
        fpend_q <= 1'b0;
      end
      if (cmd_i.ins) begin
        count_q          <= count_q + 1'b1;
        valid_q[match_q] <= 1'b0;
      end
      if (cmd_i.tscan) begin
        tpend_q <= t_issue;
        if (t_issue) begin
          tptr_q <= tptr_q + 1'b1;
        end
        if (tm) begin
          match_ok_q <= 1'b1;
        end
        // first empty slot, taken when no live entry matches
        if (tpend_q && !valid_q[tpend_idx_q] && !fs_ok_q) begin
          fs_ok_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q         <= in_action_i;
      total_q      <= 17'(in_request_i) + 17'(hdr_q);
      faddr_q      <= in_faddr_i;
      res_status_q <= ST_OK;
      res_addr_q   <= '0;
      res_bsize_q  <= '0;
      scount_q     <= '0;
    end
    if ((cmd_i.fscan || cmd_i.shdn || cmd_i.shup) && f_re) begin
      fpend_idx_q <= fptr_q[FIW-1:0];
    end
    if (cmd_i.fscan && fhit) begin
      found_q     <= fpend_idx_q;
      scount_q    <= FCW'(fpend_idx_q) + 1'b1;
      blk_start_q <= f_rdata_q.start;
      blk_len_q   <= f_rdata_q.len;
      addr_q      <= f_rdata_q.start + A'(hdr_q);
    end
    if (cmd_i.fscan && fmiss) begin
      res_status_q <= ST_NOFIT;
      scount_q     <= count_q;
    end
    if (cmd_i.tscan) begin
      if (t_issue) begin
        tpend_idx_q <= tptr_q[TIW-1:0];
      end
      if (tm) begin
        match_q <= tpend_idx_q;
      end
      if (tpend_q && !valid_q[tpend_idx_q] && !fs_ok_q) begin
        fs_q <= tpend_idx_q;
      end
    end
    if (cmd_i.fail) begin
      res_status_q <= cmd_i.fail_code;
    end
    if (cmd_i.commit) begin
      res_addr_q  <= addr_q;
      res_bsize_q <= total_q;
    end
    if (cmd_i.shup_start) begin
      pos_q  <= (pm1 > count_q) ? count_q : pm1;
      size_q <= t_rdata_q.size;
    end
    if (cmd_i.ins) begin
      res_bsize_q <= 17'(size_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_status_o  <= res_status_q;
      out_addr_o    <= res_addr_q;
      out_bsize_o   <= res_bsize_q;
      out_scount_o  <= 7'(scount_q);
      out_entries_o <= 7'(count_q);
    end
  end

endmodule

FILE: rtl/core/first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// First-fit allocator over an ordered free list with a live-allocation table.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the action (allocate,
// free, initialize), tdata the request size and the address to free. Each
// request yields one result on m_axis: tuser the status, tdata the payload
// address, block size, entries searched and the free-list length after it.
// The memory size and header size registers are written on the cfg port;
// the user must do so only while idle, as the block does not enforce it.
// One request is worked at a time. Allocate walks the free list one entry a
// cycle up to the fitting entry, then walks the allocation table one entry
// a cycle, then, on an exact fit, closes the gap one entry a cycle. Free
// walks the table, reads the entry, then opens a gap in the free list one
// entry a cycle. After reset the initial free list is built before
// s_axis_tready rises. A finished result waits in the output register while
// m_axis_tready is low; a new request is still taken, and its result waits
// until the register is free.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator #(
  parameter int FREE_LIST_DEPTH   = 64,
  parameter int ALLOC_TABLE_DEPTH = 64,
  parameter int ADDR_BITS         = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // request_size, free_address
  input  logic [((16 + ADDR_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // action
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // result_address, block_size, search_count, free_entries
  output logic [((ADDR_BITS + 31 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // status
  output logic [1:0] m_axis_tuser
);
  import ffa_pkg::*;

  localparam int OUT_DW = ((ADDR_BITS + 31 + 7) / 8) * 8;

  ffa_cmd_t  cmd;
  ffa_stat_t stat;
  logic [ADDR_BITS-1:0] out_addr;
  logic [16:0] out_bsize;
  logic [6:0]  out_scount, out_entries;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffa_dp #(
    .FREE_LIST_DEPTH   (FREE_LIST_DEPTH),
    .ALLOC_TABLE_DEPTH (ALLOC_TABLE_DEPTH),
    .ADDR_BITS         (ADDR_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_action_i   (s_axis_tuser),
    .in_request_i  (s_axis_tdata[15:0]),
    .in_faddr_i    (s_axis_tdata[16 +: ADDR_BITS]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_status_o  (m_axis_tuser),
    .out_addr_o    (out_addr),
    .out_bsize_o   (out_bsize),
    .out_scount_o  (out_scount),
    .out_entries_o (out_entries)
  );

  assign m_axis_tdata = OUT_DW'({out_entries, out_scount, out_bsize, out_addr});

endmodule

FILE: rtl/core/ffa_checker.sv
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffa_checker #(
  parameter int FREE_LIST_DEPTH   = 64,
  parameter int ADDR_BITS         = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((ADDR_BITS + 31 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);
  import ffa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one request in work at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in work");

  // a miss reports neither address nor size
  a_nofit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_NOFIT) |->
      (m_axis_tdata[ADDR_BITS + 16:0] == '0))
    else $error("miss carries address or size");

  // list length bounded by its depth
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (FREE_LIST_DEPTH > 127) ||
      (m_axis_tdata[ADDR_BITS + 30 -: 7] <= 7'(FREE_LIST_DEPTH)))
    else $error("free-list length beyond depth");

endmodule

bind first_fit_free_list_allocator ffa_checker #(
  .FREE_LIST_DEPTH   (FREE_LIST_DEPTH),
  .ADDR_BITS         (ADDR_BITS)
) u_ffa_checker (.*);
